// ===== hdl/dmrpd_pkg.sv =====
// Shared types, widths, codes and reset values for the dual motor ramped PWM duty block.
// Used by the channel interfaces, the bridge duty module and the top level.
`default_nettype none

package dmrpd_pkg;

	// Field and register widths.
	localparam int SPEED_W             = 12;
	localparam int DUTY_W              = 12;
	localparam int STEP_W              = 11;
	localparam int BASE_W              = 8;
	localparam int SCALE_W             = 6;
	localparam int ACTION_W            = 2;
	localparam int SPEED_FRACTION_BITS = 4;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = STEP_W;

	// Limits.
	localparam logic [DUTY_W-1:0]         DUTY_MAX  = 12'd4095;
	localparam logic signed [SPEED_W-1:0] SPEED_MAX = 12'sd2047;

	// Register reset values.
	localparam logic [STEP_W-1:0]  ACCEL_RESET = 11'd80;
	localparam logic [BASE_W-1:0]  BASE_RESET  = 8'd50;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 6'd24;

	// Input word actions; the fourth code changes nothing.
	typedef enum logic [ACTION_W-1:0] {
		ACT_SET  = 2'd0,
		ACT_SLOW = 2'd1,
		ACT_TICK = 2'd2
	} action_t;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ACCEL = 2'd0,
		REG_BASE  = 2'd1,
		REG_SCALE = 2'd2
	} reg_index_t;

	// Duty settings handed to each bridge.
	typedef struct packed {
		logic [BASE_W-1:0]  base_duty;
		logic [SCALE_W-1:0] duty_per_percent;
	} duty_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/dmrpd_if.sv =====
// Valid/ready channel interfaces for the command words and the result words.
// Depends on dmrpd_pkg for field widths.
`default_nettype none

interface dmrpd_cmd_if;
	logic                                  valid;
	logic                                  ready;
	logic [dmrpd_pkg::ACTION_W-1:0]        action;
	logic                                  motor;
	logic signed [dmrpd_pkg::SPEED_W-1:0]  amount;

	modport source (output valid, action, motor, amount, input ready);
	modport sink   (input valid, action, motor, amount, output ready);
endinterface

interface dmrpd_res_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [dmrpd_pkg::SPEED_W-1:0]  left_speed;
	logic signed [dmrpd_pkg::SPEED_W-1:0]  right_speed;
	logic [dmrpd_pkg::DUTY_W-1:0]          left_primary_duty;
	logic [dmrpd_pkg::DUTY_W-1:0]          left_secondary_duty;
	logic [dmrpd_pkg::DUTY_W-1:0]          right_primary_duty;
	logic [dmrpd_pkg::DUTY_W-1:0]          right_secondary_duty;

	modport source (output valid, left_speed, right_speed, left_primary_duty,
		left_secondary_duty, right_primary_duty, right_secondary_duty, input ready);
	modport sink   (input valid, left_speed, right_speed, left_primary_duty,
		left_secondary_duty, right_primary_duty, right_secondary_duty, output ready);
endinterface

`default_nettype wire

// ===== hdl/dmrpd_bridge.sv =====
// H-bridge duty pair for one motor channel, derived from its signed speed.
// Depends on dmrpd_pkg for widths, the duty limit and the duty settings struct.
`default_nettype none

module dmrpd_bridge (
	input  wire dmrpd_pkg::duty_cfg_t                 cfg,
	input  wire logic signed [dmrpd_pkg::SPEED_W-1:0] speed,
	output logic [dmrpd_pkg::DUTY_W-1:0]              primary_duty,
	output logic [dmrpd_pkg::DUTY_W-1:0]              secondary_duty
);

	localparam int PROD_W   = dmrpd_pkg::SPEED_W + dmrpd_pkg::SCALE_W;
	localparam int SCALED_W = PROD_W - dmrpd_pkg::SPEED_FRACTION_BITS;
	localparam int SUM_W    = SCALED_W + 1;

	logic [dmrpd_pkg::SPEED_W-1:0] mag;
	logic [PROD_W-1:0]             product;
	logic [SCALED_W-1:0]           scaled;
	logic [SUM_W-1:0]              drive_sum;
	logic [dmrpd_pkg::DUTY_W-1:0]  drive_duty;
	logic [dmrpd_pkg::DUTY_W-1:0]  base_duty;
	logic                          forward;

	// Magnitude of the speed; the most negative speed still fits unsigned.
	assign mag = speed[dmrpd_pkg::SPEED_W-1] ? dmrpd_pkg::SPEED_W'(-speed)
		: dmrpd_pkg::SPEED_W'(speed);

	// Scale to duty counts, drop the fraction, add the base and saturate.
	assign product    = PROD_W'(mag) * PROD_W'(cfg.duty_per_percent);
	assign scaled     = product[PROD_W-1:dmrpd_pkg::SPEED_FRACTION_BITS];
	assign drive_sum  = SUM_W'(scaled) + SUM_W'(cfg.base_duty);
	assign drive_duty = (drive_sum > SUM_W'(dmrpd_pkg::DUTY_MAX)) ? dmrpd_pkg::DUTY_MAX
		: drive_sum[dmrpd_pkg::DUTY_W-1:0];
	assign base_duty  = dmrpd_pkg::DUTY_W'(cfg.base_duty);

	// The side of the direction of motion gets the drive duty; the other side holds the base duty.
	assign forward        = !speed[dmrpd_pkg::SPEED_W-1] && (speed != '0);
	assign primary_duty   = forward ? drive_duty : base_duty;
	assign secondary_duty = forward ? base_duty : drive_duty;

endmodule

`default_nettype wire

// ===== hdl/dual_motor_ramped_pwm_duty.sv =====
// Stages: a command word passes through the input register and then the output register,
// the two stages, to become a result word.
// Throughput: one word per cycle while result words are taken; a stalled result word holds the
// input register, so only one more word is taken while it waits.
// Reset (arst_n low) clears targets and speeds and loads step 80, base 50, scale 24.
// Depends on dmrpd_pkg, dmrpd_if and dmrpd_bridge.
`default_nettype none

module dual_motor_ramped_pwm_duty (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [dmrpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [dmrpd_pkg::CFG_DATA_W-1:0]    cfg_data,
	dmrpd_cmd_if.sink                                cmd,
	dmrpd_res_if.source                              res
);

	localparam int SPEED_W = dmrpd_pkg::SPEED_W;
	localparam int WIDE_W  = SPEED_W + 2;

	// Configuration registers.
	logic [dmrpd_pkg::STEP_W-1:0]  accel_q;
	logic [dmrpd_pkg::BASE_W-1:0]  base_q;
	logic [dmrpd_pkg::SCALE_W-1:0] scale_q;

	// Input register.
	logic                           valid_s1;
	logic [dmrpd_pkg::ACTION_W-1:0] action_s1;
	logic                           motor_s1;
	logic signed [SPEED_W-1:0]      amount_s1;

	// Speed state.
	logic signed [SPEED_W-1:0] left_tgt_q, right_tgt_q, left_cur_q, right_cur_q;
	logic signed [SPEED_W-1:0] left_tgt_d, right_tgt_d, left_cur_d, right_cur_d;

	// Output register.
	logic                               res_valid_q;
	logic signed [SPEED_W-1:0]          left_speed_q, right_speed_q;
	logic [dmrpd_pkg::DUTY_W-1:0]       lp_duty_q, ls_duty_q, rp_duty_q, rs_duty_q;
	logic [dmrpd_pkg::DUTY_W-1:0]       lp_duty, ls_duty, rp_duty, rs_duty;

	dmrpd_pkg::duty_cfg_t duty_cfg;
	logic                 advance;

	// Move the current speed toward the target by at most one step.
	function automatic logic signed [SPEED_W-1:0] ramp(
		input logic signed [SPEED_W-1:0]       cur,
		input logic signed [SPEED_W-1:0]       tgt,
		input logic [dmrpd_pkg::STEP_W-1:0]    step
	);
		logic signed [WIDE_W-1:0] diff;
		logic signed [WIDE_W-1:0] step_w;
		logic signed [WIDE_W-1:0] res_w;
		diff   = WIDE_W'(tgt) - WIDE_W'(cur);
		step_w = $signed(WIDE_W'(step));
		if (diff > step_w) begin
			res_w = WIDE_W'(cur) + step_w;
		end else if (diff < -step_w) begin
			res_w = WIDE_W'(cur) - step_w;
		end else begin
			res_w = WIDE_W'(tgt);
		end
		return res_w[SPEED_W-1:0];
	endfunction

	// New target for a slow-down: only a channel moving forward is touched.
	function automatic logic signed [SPEED_W-1:0] slowed(
		input logic signed [SPEED_W-1:0] cur,
		input logic signed [SPEED_W-1:0] tgt,
		input logic signed [SPEED_W-1:0] dec
	);
		logic signed [WIDE_W-1:0] t;
		logic signed [SPEED_W-1:0] res_s;
		t = WIDE_W'(cur) - WIDE_W'(dec);
		if (cur <= 0) begin
			res_s = tgt;
		end else if (t < 0) begin
			res_s = '0;
		end else if (t > WIDE_W'(dmrpd_pkg::SPEED_MAX)) begin
			res_s = dmrpd_pkg::SPEED_MAX;
		end else begin
			res_s = t[SPEED_W-1:0];
		end
		return res_s;
	endfunction

	// Configuration writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q <= dmrpd_pkg::ACCEL_RESET;
			base_q  <= dmrpd_pkg::BASE_RESET;
			scale_q <= dmrpd_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dmrpd_pkg::REG_ACCEL: accel_q <= cfg_data;
				dmrpd_pkg::REG_BASE:  base_q  <= cfg_data[dmrpd_pkg::BASE_W-1:0];
				dmrpd_pkg::REG_SCALE: scale_q <= cfg_data[dmrpd_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// The input register moves on whenever the output register is free or being taken.
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			action_s1 <= cmd.action;
			motor_s1  <= cmd.motor;
			amount_s1 <= cmd.amount;
		end
	end

	// Next speed state for the word in the input register.
	always_comb begin
		left_tgt_d  = left_tgt_q;
		right_tgt_d = right_tgt_q;
		left_cur_d  = left_cur_q;
		right_cur_d = right_cur_q;
		case (action_s1)
			dmrpd_pkg::ACT_SET: begin
				if (motor_s1) begin
					right_tgt_d = amount_s1;
				end else begin
					left_tgt_d = amount_s1;
				end
			end
			dmrpd_pkg::ACT_SLOW: begin
				left_tgt_d  = slowed(left_cur_q, left_tgt_q, amount_s1);
				right_tgt_d = slowed(right_cur_q, right_tgt_q, amount_s1);
			end
			dmrpd_pkg::ACT_TICK: begin
				left_cur_d  = ramp(left_cur_q, left_tgt_q, accel_q);
				right_cur_d = ramp(right_cur_q, right_tgt_q, accel_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_tgt_q  <= '0;
			right_tgt_q <= '0;
			left_cur_q  <= '0;
			right_cur_q <= '0;
		end else if (advance) begin
			left_tgt_q  <= left_tgt_d;
			right_tgt_q <= right_tgt_d;
			left_cur_q  <= left_cur_d;
			right_cur_q <= right_cur_d;
		end
	end

	// Bridge duties from the updated speeds.
	assign duty_cfg.base_duty        = base_q;
	assign duty_cfg.duty_per_percent = scale_q;

	dmrpd_bridge u_left_bridge (
		.cfg            (duty_cfg),
		.speed          (left_cur_d),
		.primary_duty   (lp_duty),
		.secondary_duty (ls_duty)
	);

	dmrpd_bridge u_right_bridge (
		.cfg            (duty_cfg),
		.speed          (right_cur_d),
		.primary_duty   (rp_duty),
		.secondary_duty (rs_duty)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			left_speed_q  <= left_cur_d;
			right_speed_q <= right_cur_d;
			lp_duty_q     <= lp_duty;
			ls_duty_q     <= ls_duty;
			rp_duty_q     <= rp_duty;
			rs_duty_q     <= rs_duty;
		end
	end

	assign res.valid                = res_valid_q;
	assign res.left_speed           = left_speed_q;
	assign res.right_speed          = right_speed_q;
	assign res.left_primary_duty    = lp_duty_q;
	assign res.left_secondary_duty  = ls_duty_q;
	assign res.right_primary_duty   = rp_duty_q;
	assign res.right_secondary_duty = rs_duty_q;

`ifndef SYNTHESIS
	// A current speed changes only through a tick word leaving the input register.
	a_speed_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(left_cur_q != $past(left_cur_q) || right_cur_q != $past(right_cur_q))
		|-> $past(advance && action_s1 == dmrpd_pkg::ACT_TICK))
		else $error("current speed changed without a tick");

	// A slow-down never leaves the left channel, when moving forward, with a negative target.
	a_slow_target_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && action_s1 == dmrpd_pkg::ACT_SLOW && left_cur_q > 0)
		|=> !left_tgt_q[SPEED_W-1])
		else $error("slow-down produced a negative target");

	// With the output register empty, a new word is always taken.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> cmd.ready)
		else $error("input stalled with empty output register");
`endif

endmodule

`default_nettype wire
